@@ hw/rtl/etld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge timestamp log decoder package
// Shared widths, lead byte codes and the beat and event structs.
// ----------------------------------------------------------------------------
package etld_pkg;

	localparam int BYTE_W = 8;
	localparam int HIGH_W = 6;
	localparam int OFS_W  = HIGH_W + BYTE_W;
	localparam int STEP_W = BYTE_W + OFS_W;
	localparam int TIME_W = 32;
	localparam int OUT_W  = 32;

	localparam logic [1:0] KIND_DOWN = 2'b10;
	localparam logic [1:0] KIND_UP   = 2'b01;

	localparam logic [OFS_W-1:0] WRAP_FIX = 14'h3fff;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} etld_beat_t;

	typedef struct packed {
		logic             edge_down;
		logic [OUT_W-1:0] event_time;
		logic [OUT_W-1:0] event_delta;
	} etld_event_t;

endpackage

@@ hw/rtl/edge_timestamp_log_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge timestamp log decoder
// Decodes a byte stream of edge events into kind, time and delta beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one log byte per beat. A lead
//   byte 10xxxxxx (falling) or 01xxxxxx (rising) opens an event; the next
//   byte closes it. Other lead bytes advance the time base by byte * 16383.
//   Output channel out_valid/out_stall carries one event beat per closed
//   event: edge_down, event_time, event_delta.
//   The closing byte is registered in the input register, and its event
//   beat then in the result register once that register is free.
//   Throughput: one byte per cycle while no closing byte waits, set by the
//   single decode stage between the input register and the result register.
//   Stall: the result register holds while out_stall is high; bytes that
//   yield no event still flow through, a closing byte waits in the input
//   register and in_stall rises.
//   Reset: clears time base, previous time and any pending event; both
//   channels come up empty.
// ----------------------------------------------------------------------------
module edge_timestamp_log_decoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [etld_pkg::BYTE_W-1:0]    data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           edge_down,
	output logic [etld_pkg::OUT_W-1:0]     event_time,
	output logic [etld_pkg::OUT_W-1:0]     event_delta
);
	import etld_pkg::*;

	etld_beat_t  beat;
	etld_event_t evt;
	logic        take;
	logic        emit;
	logic        out_free;

	etld_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.take      (take),
		.beat      (beat)
	);

	etld_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat     (beat),
		.out_free (out_free),
		.take     (take),
		.emit     (emit),
		.evt      (evt)
	);

	etld_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit        (emit),
		.evt         (evt),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.edge_down   (edge_down),
		.event_time  (event_time),
		.event_delta (event_delta)
	);

endmodule

@@ hw/rtl/etld_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge timestamp log decoder input stage
// Holds one incoming byte beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module etld_in_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [etld_pkg::BYTE_W-1:0]       data_byte,
	input  logic                              take,
	output etld_pkg::etld_beat_t              beat
);
	import etld_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              accept;

	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
		end
	end

	assign beat.valid = valid_s1;
	assign beat.data  = data_s1;

endmodule

@@ hw/rtl/etld_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge timestamp log decoder decode stage
// Holds time base and event state, decodes one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module etld_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  etld_pkg::etld_beat_t   beat,
	input  logic                   out_free,
	output logic                   take,
	output logic                   emit,
	output etld_pkg::etld_event_t  evt
);
	import etld_pkg::*;

	logic              awaiting_low_q;
	logic              held_kind_q;
	logic [HIGH_W-1:0] held_high_q;
	logic [TIME_W-1:0] time_base_q;
	logic [TIME_W-1:0] prev_time_q;

	logic [OFS_W-1:0]  offset;
	logic [TIME_W-1:0] ev_time;
	logic [TIME_W-1:0] diff;
	logic [TIME_W-1:0] delta;
	logic [STEP_W-1:0] base_step;
	logic              lead;
	logic              is_down;

	assign offset  = {held_high_q, beat.data};
	assign ev_time = time_base_q + TIME_W'(offset);
	assign diff    = ev_time - prev_time_q;
	assign delta   = (ev_time < prev_time_q) ? diff + TIME_W'(WRAP_FIX) : diff;

	// byte * 0x3fff as (byte << 14) - byte
	assign base_step = {beat.data, OFS_W'(0)} - STEP_W'(beat.data);

	assign is_down = (beat.data[BYTE_W-1 -: 2] == KIND_DOWN);
	assign lead    = is_down || (beat.data[BYTE_W-1 -: 2] == KIND_UP);

	assign take = beat.valid && (!awaiting_low_q || out_free);
	assign emit = beat.valid && awaiting_low_q && out_free;

	assign evt.edge_down   = held_kind_q;
	assign evt.event_time  = OUT_W'(ev_time);
	assign evt.event_delta = OUT_W'(delta);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_low_q <= 1'b0;
			held_kind_q    <= 1'b0;
			held_high_q    <= '0;
			time_base_q    <= '0;
			prev_time_q    <= '0;
		end else if (take) begin
			if (awaiting_low_q) begin
				awaiting_low_q <= 1'b0;
				prev_time_q    <= ev_time;
			end else if (lead) begin
				awaiting_low_q <= 1'b1;
				held_kind_q    <= is_down;
				held_high_q    <= beat.data[HIGH_W-1:0];
			end else begin
				time_base_q <= time_base_q + TIME_W'(base_step);
			end
		end
	end

endmodule

@@ hw/rtl/etld_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge timestamp log decoder output stage
// Result register for one event beat, held while the receiver stalls.
// ----------------------------------------------------------------------------
module etld_out_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           emit,
	input  etld_pkg::etld_event_t          evt,
	output logic                           out_free,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           edge_down,
	output logic [etld_pkg::OUT_W-1:0]     event_time,
	output logic [etld_pkg::OUT_W-1:0]     event_delta
);
	import etld_pkg::*;

	logic        valid_q;
	etld_event_t evt_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			evt_q <= evt;
		end
	end

	assign out_valid   = valid_q;
	assign edge_down   = evt_q.edge_down;
	assign event_time  = evt_q.event_time;
	assign event_delta = evt_q.event_delta;

endmodule

@@ hw/rtl/etld_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge timestamp log decoder checker
// Port level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module etld_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [etld_pkg::BYTE_W-1:0]    data_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           edge_down,
	input  logic [etld_pkg::OUT_W-1:0]     event_time,
	input  logic [etld_pkg::OUT_W-1:0]     event_delta
);
	import etld_pkg::*;

	logic [OUT_W-1:0] prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (out_valid && !out_stall) begin
			prev_q <= event_time;
		end
	end

	// delta follows from this and the previous event time
	a_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_time >= prev_q) ? (event_delta == event_time - prev_q)
			: (event_delta == event_time + OUT_W'(WRAP_FIX) - prev_q)))
		else $error("event delta mismatch");

	// a new event beat follows a byte accepted through the input and result registers
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("event beat without a closing byte");

	// input only backs up behind a stalled result
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with output free");

	// stalled event beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(edge_down)
			&& $stable(event_time) && $stable(event_delta)))
		else $error("stalled event beat changed");

endmodule

bind edge_timestamp_log_decoder_core etld_checker u_chk (.*);

@@ verif/edge_timestamp_log_decoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge timestamp log decoder testbench
// Feeds log bytes with random gaps and output stalls, predicts every event
// beat from a local decode of the stream and checks kind, time and delta in
// order. Covers lead and base bytes, wrap-fixed deltas, time wrap, a long
// output hold that backs up the input, and a lead byte left open at the end.
// ----------------------------------------------------------------------------
module edge_timestamp_log_decoder_core_test;

	import etld_pkg::*;

	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          RANDOM_BYTES   = 500;
	localparam int          QUIET_BYTES    = 100;
	localparam logic [1:0]  BASE_LO        = 2'b00;
	localparam logic [1:0]  BASE_HI        = 2'b11;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte   = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              edge_down;
	logic [OUT_W-1:0]  event_time;
	logic [OUT_W-1:0]  event_delta;

	// local decode state
	logic              pend_open;
	logic              pend_down;
	logic [HIGH_W-1:0] pend_high;
	logic [TIME_W-1:0] base_time;
	logic [TIME_W-1:0] last_event_time;

	etld_event_t expected_events[$];
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	bit          send_idle_on   = 1'b1;
	bit          recv_idle_on   = 1'b1;
	bit          hold_req       = 1'b0;
	int          stall_left     = 0;

	edge_timestamp_log_decoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.edge_down   (edge_down),
		.event_time  (event_time),
		.event_delta (event_delta)
	);

	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic predict_event(input logic [BYTE_W-1:0] b);
		etld_event_t       ev;
		logic [TIME_W-1:0] t;
		if (pend_open) begin
			t = base_time + TIME_W'({pend_high, b});
			ev.edge_down  = pend_down;
			ev.event_time = t;
			if (t >= last_event_time)
				ev.event_delta = t - last_event_time;
			else
				ev.event_delta = t + TIME_W'(WRAP_FIX) - last_event_time;
			expected_events.push_back(ev);
			last_event_time = t;
			pend_open = 1'b0;
		end else if (b[7:6] == KIND_DOWN || b[7:6] == KIND_UP) begin
			pend_down = (b[7:6] == KIND_DOWN);
			pend_high = b[HIGH_W-1:0];
			pend_open = 1'b1;
		end else begin
			base_time = base_time + TIME_W'(b) * TIME_W'(WRAP_FIX);
		end
	endtask

	task automatic send_byte_after(input logic [BYTE_W-1:0] b, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_event(b);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = 0;
		if (send_idle_on && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 16);
		send_byte_after(b, gap);
	endtask

	task automatic release_sender();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_random_event();
		logic [1:0] kind;
		kind = $urandom_range(0, 1) ? KIND_DOWN : KIND_UP;
		send_byte({kind, HIGH_W'($urandom_range(0, 63))});
		send_byte(BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic test_directed();
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h7f);
		send_byte(8'hff);
		send_byte(8'h40);
		send_byte(8'h00);
		// closing byte that looks like a lead byte
		send_byte(8'hbf);
		send_byte(8'h80);
		// earlier time than last event: delta takes the wrap fix
		send_byte(8'h81);
		send_byte(8'h40);
		send_byte(8'hff);
		send_byte(8'hc0);
		send_byte(8'h3f);
		send_byte(8'h01);
		send_byte(8'ha5);
		send_byte(8'h5a);
		// open event held over a long gap
		send_byte(8'h55);
		send_byte_after(8'haa, 20);
		release_sender();
	endtask

	task automatic test_back_pressure();
		hold_req = 1'b1;
		repeat (30) send_random_event();
		release_sender();
	endtask

	task automatic test_random();
		int sent;
		int pick;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			if (sent >= RANDOM_BYTES - QUIET_BYTES) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_random_event();
				sent += 2;
			end else if (pick < 90) begin
				send_byte({($urandom_range(0, 1) ? BASE_HI : BASE_LO),
					HIGH_W'($urandom_range(0, 63))});
				sent++;
			end else begin
				send_byte(BYTE_W'($urandom_range(0, 255)));
				sent++;
			end
		end
		release_sender();
	endtask

	task automatic test_time_wrap();
		while (base_time < 32'hff80_0000)
			send_byte(8'hff);
		repeat (4) begin
			send_random_event();
			send_byte(8'hff);
		end
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h7f);
		send_byte(8'hff);
		release_sender();
	endtask

	task automatic test_truncated_tail();
		send_byte(8'h9c);
		release_sender();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req   = 1'b0;
			stall_left = HOLD_CYCLES;
		end else if (stall_left == 0 && recv_idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16);
		end
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		etld_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				report_error($sformatf("unexpected event beat kind=%0d time=%0h delta=%0h",
					edge_down, event_time, event_delta));
			end else begin
				want = expected_events.pop_front();
				if (edge_down !== want.edge_down)
					report_error($sformatf("edge_down got %0d want %0d",
						edge_down, want.edge_down));
				if (event_time !== want.event_time)
					report_error($sformatf("event_time got %0h want %0h",
						event_time, want.event_time));
				if (event_delta !== want.event_delta)
					report_error($sformatf("event_delta got %0h want %0h",
						event_delta, want.event_delta));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		pend_open       = 1'b0;
		pend_down       = 1'b0;
		pend_high       = '0;
		base_time       = '0;
		last_event_time = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_back_pressure();
		test_random();
		test_time_wrap();
		test_truncated_tail();
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/etld_pkg.sv
hw/rtl/etld_in_stage.sv
hw/rtl/etld_decode.sv
hw/rtl/etld_out_stage.sv
hw/rtl/edge_timestamp_log_decoder_core.sv
hw/rtl/etld_checker.sv
verif/edge_timestamp_log_decoder_core_test.sv
